// ===== hdl/battery_voltage_moving_average_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef BATTERY_VOLTAGE_MOVING_AVERAGE_DEFINES_SVH
`define BATTERY_VOLTAGE_MOVING_AVERAGE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BVMA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bvma assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define BVMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bvma assertion failed");

`endif

// ===== hdl/bvma_pkg.sv =====
package bvma_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int SCALE_W    = 16;
    localparam int VOLT_W     = 16;
    localparam int PROD_W     = SAMPLE_W + SCALE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 2'd1;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd418;
    localparam logic [SCALE_W-1:0]  SCALE_RESET     = 16'd1856;
    localparam logic [SAMPLE_W-1:0] ADC_MAX         = 10'd1023;

    typedef struct packed {
        logic [SAMPLE_W-1:0] low_threshold;
        logic [SCALE_W-1:0]  full_scale;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] average_raw;
        logic [VOLT_W-1:0]   voltage_centivolts;
        logic                battery_low;
        logic                window_full;
    } result_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_UPDATE,
        BK_DIV,
        BK_MUL,
        BK_SCALE
    } back_state_t;

endpackage

// ===== hdl/bvma_ram.sv =====
module bvma_ram
    import bvma_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== hdl/bvma_fifo.sv =====
module bvma_fifo
    import bvma_pkg::*;
#(
    parameter int WIDTH = 10,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_MAX);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/bvma_front.sv =====
module bvma_front
    import bvma_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  full,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output logic                  smp_valid,
    output logic [SAMPLE_W-1:0]   smp_data,
    input  logic                  smp_pop
);

    cfg_t cfg_reg, cfg_next;
    logic smp_empty;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign smp_valid = !smp_empty;

    // Writes to an index beyond the register list leave both registers alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOW_THRESHOLD: cfg_next.low_threshold = cfg_data[SAMPLE_W-1:0];
                REG_FULL_SCALE:    cfg_next.full_scale    = cfg_data[SCALE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold <= THRESHOLD_RESET;
            cfg_reg.full_scale    <= SCALE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bvma_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (2)
    ) u_sample_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (sample),
        .full  (full),
        .pop   (smp_pop),
        .rdata (smp_data),
        .empty (smp_empty)
    );

endmodule

// ===== hdl/bvma_back.sv =====
module bvma_back
    import bvma_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                smp_valid,
    input  logic [SAMPLE_W-1:0] smp_data,
    output logic                smp_pop,
    input  logic                res_full,
    output logic                res_push,
    output result_t             res_data
);

    localparam int PTR_W  = $clog2(WINDOW);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam logic [PTR_W-1:0]  LAST_POS = PTR_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);
    localparam logic [CNT_W-1:0]  LAST_CNT = CNT_W'(SUM_W - 1);

    back_state_t state_reg, state_next;

    logic [PTR_W-1:0]    pos_reg, pos_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SUM_W-1:0]    dvd_reg;
    logic [FILL_W-1:0]   rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PROD_W-1:0]   prod_reg;

    logic                ram_we;
    logic [SAMPLE_W-1:0] old_raw;
    logic [SAMPLE_W-1:0] old_entry;
    logic [FILL_W:0]     rem_shift;
    logic                rem_ge;
    logic [SAMPLE_W-1:0] avg;
    logic                ring_full;

    logic [SCALE_W-1:0]  hi_part;
    logic [SCALE_W:0]    fold1;
    logic [SCALE_W-SAMPLE_W:0] fold1_hi;
    logic [SAMPLE_W:0]   fold2;
    logic                round_up;
    logic [VOLT_W-1:0]   volts;

    bvma_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (old_raw)
    );

    // While the ring is still filling, the slot at the write position has
    // never been written and stands for zero.
    assign ring_full = (fill_reg == FILL_MAX);
    assign old_entry = ring_full ? old_raw : '0;
    assign avg       = dvd_reg[SAMPLE_W-1:0];

    assign rem_shift = {rem_reg, dvd_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, fill_reg});

    // Division by 1023 using 1024 = 1023 + 1: fold the high part back twice,
    // then one compare settles the last quotient bit.
    assign hi_part  = prod_reg[PROD_W-1:SAMPLE_W];
    assign fold1    = {1'b0, hi_part} + (SCALE_W + 1)'(prod_reg[SAMPLE_W-1:0]);
    assign fold1_hi = fold1[SCALE_W:SAMPLE_W];
    assign fold2    = (SAMPLE_W + 1)'(fold1_hi) + (SAMPLE_W + 1)'(fold1[SAMPLE_W-1:0]);
    assign round_up = (fold2 >= (SAMPLE_W + 1)'(ADC_MAX));
    assign volts    = VOLT_W'(hi_part + SCALE_W'(fold1_hi) + SCALE_W'(round_up));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (smp_valid) state_next = BK_UPDATE;
            BK_UPDATE: state_next = BK_DIV;
            BK_DIV:    if (cnt_reg == LAST_CNT) state_next = BK_MUL;
            BK_MUL:    state_next = BK_SCALE;
            BK_SCALE:  if (!res_full) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        smp_pop  = 1'b0;
        ram_we   = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            BK_IDLE:   smp_pop  = smp_valid;
            BK_UPDATE: ram_we   = 1'b1;
            BK_SCALE:  res_push = !res_full;
            default:   smp_pop  = 1'b0;
        endcase
    end

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        sum_next  = sum_reg;
        if (state_reg == BK_UPDATE)
        begin
            pos_next  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            fill_next = ring_full ? fill_reg : fill_reg + 1'b1;
            sum_next  = sum_reg - SUM_W'(old_entry) + SUM_W'(sample_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            pos_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    // Sample capture, and a restoring divider: one quotient bit a cycle, the
    // quotient shifting in behind the dividend; then the full-scale multiply.
    always_ff @(posedge clk)
    begin
        if (smp_pop)
        begin
            sample_reg <= smp_data;
        end
        case (state_reg)
            BK_UPDATE:
            begin
                dvd_reg <= sum_next;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            BK_DIV:
            begin
                rem_reg <= rem_ge ? FILL_W'(rem_shift - {1'b0, fill_reg})
                                  : rem_shift[FILL_W-1:0];
                dvd_reg <= {dvd_reg[SUM_W-2:0], rem_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            BK_MUL:
            begin
                prod_reg <= PROD_W'(avg) * PROD_W'(cfg.full_scale);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_data.average_raw        = avg;
        res_data.voltage_centivolts = volts;
        res_data.battery_low        = (avg <= cfg.low_threshold);
        res_data.window_full        = ring_full;
    end

endmodule

// ===== hdl/battery_voltage_moving_average.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         push / full                sample
// result    out        empty / pop                average_raw, voltage_centivolts,
//                                                 battery_low, window_full
// config    in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each item runs the back-end states idle, update, divide, multiply and scale in
// turn; the one-bit-a-cycle divider divides the running sum by the fill count.
// An item waits in the two-entry sample queue before it starts.
// Reset empties both queues, zeroes the sum and fill count and loads the register
// defaults; the sample ring itself is not cleared, the fill count masks it.
// A full result queue holds the back end, which then lets the sample queue fill.
`include "battery_voltage_moving_average_defines.svh"

module battery_voltage_moving_average
    import bvma_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [SAMPLE_W-1:0]   sample,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output logic [SAMPLE_W-1:0]   average_raw,
    output logic [VOLT_W-1:0]     voltage_centivolts,
    output logic                  battery_low,
    output logic                  window_full,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                cfg;
    logic                smp_valid;
    logic [SAMPLE_W-1:0] smp_data;
    logic                smp_pop;
    logic                res_full;
    logic                res_push;
    result_t             res_data;
    result_t             res_out;

    bvma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .sample    (sample),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .smp_valid (smp_valid),
        .smp_data  (smp_data),
        .smp_pop   (smp_pop)
    );

    bvma_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .smp_valid (smp_valid),
        .smp_data  (smp_data),
        .smp_pop   (smp_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    bvma_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (2)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign average_raw        = res_out.average_raw;
    assign voltage_centivolts = res_out.voltage_centivolts;
    assign battery_low        = res_out.battery_low;
    assign window_full        = res_out.window_full;

    `BVMA_ASSERT_IMPLIES(a_result_push_has_room, res_push, !res_full)
    `BVMA_ASSERT_NEXT(a_result_visible_after_push, res_push, !empty)
    `BVMA_ASSERT_IMPLIES(a_sample_pop_has_item, smp_pop, smp_valid)
    `BVMA_ASSERT_IMPLIES(a_no_take_while_pushing, smp_pop, !res_push)

endmodule
